// File: rtl/lprt_pkg.sv
// Shared types, operation and status codes, and a helper function for the route table.
package lprt_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned LEN_W  = 6;
  localparam int unsigned PORT_W = 8;
  localparam int unsigned MET_W  = 32;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_DELETE = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  localparam logic [1:0] STATUS_DONE      = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_REPLACED  = 2'd2;
  localparam logic [1:0] STATUS_FULL      = 2'd3;

  typedef struct packed {
    logic [1:0]        func;
    logic [ADDR_W-1:0] prefix_addr;
    logic [LEN_W-1:0]  prefix_len;
    logic [ADDR_W-1:0] next_hop;
    logic [PORT_W-1:0] port;
    logic [MET_W-1:0]  metric;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] found_next_hop;
    logic [PORT_W-1:0] found_port;
    logic [MET_W-1:0]  found_metric;
  } rsp_t;

  // Command travelling along the row of cells. For a query, len holds the
  // length of the best match so far and the route fields hold its data.
  typedef struct packed {
    logic              vld;
    logic [1:0]        func;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    logic              hit;
    logic              free_found;
    logic [ADDR_W-1:0] next_hop;
    logic [PORT_W-1:0] port;
    logic [MET_W-1:0]  metric;
  } tok_t;

  // Write of a new route into the lowest free cell at the end of an insert.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] prefix;
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] next_hop;
    logic [PORT_W-1:0] port;
    logic [MET_W-1:0]  metric;
  } wr_t;

  function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
    len_mask = ~({ADDR_W{1'b1}} >> len);
  endfunction

endpackage

// File: rtl/longest_prefix_route_table.sv
// Longest-prefix-match IPv4 route table built as a row of route cells.
// An accepted command is registered, then passes one cell per cycle along the row of
// TABLE_ENTRIES cells; the result and done are registered after the last cell.
// A new command is not taken while busy, which holds until the previous one leaves the last cell.
// The receiver cannot stall: each result is shown for one cycle with done high.
// Synchronous reset clears every route's valid bit at once; start is taken the cycle after.
module longest_prefix_route_table #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  lprt_pkg::cmd_t cmd,
  output logic           busy,
  output logic           done,
  output lprt_pkg::rsp_t rsp
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic                          accept;
  logic [lprt_pkg::LEN_W-1:0]    len_sat;
  lprt_pkg::tok_t                tok_launch;
  lprt_pkg::tok_t                chain_tok [0:TABLE_ENTRIES];
  logic [IDX_W-1:0]              chain_idx [0:TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0]      chain_vld;
  lprt_pkg::tok_t                last;
  lprt_pkg::wr_t                 wr;
  lprt_pkg::rsp_t                rsp_next;

  assign accept  = start && !busy;
  assign len_sat = (cmd.prefix_len > lprt_pkg::MAX_LEN) ? lprt_pkg::MAX_LEN : cmd.prefix_len;

  always_ff @(posedge clk) begin
    if (accept) begin
      tok_launch.func       <= cmd.func;
      tok_launch.hit        <= 1'b0;
      tok_launch.free_found <= 1'b0;
      tok_launch.next_hop   <= cmd.next_hop;
      tok_launch.port       <= cmd.port;
      tok_launch.metric     <= cmd.metric;
      if (cmd.func == lprt_pkg::FUNC_QUERY) begin
        tok_launch.addr <= cmd.prefix_addr;
        tok_launch.len  <= '0;
      end else begin
        tok_launch.addr <= cmd.prefix_addr & lprt_pkg::len_mask(len_sat);
        tok_launch.len  <= len_sat;
      end
    end
    if (rst) begin
      tok_launch.vld <= 1'b0;
    end else begin
      tok_launch.vld <= accept;
    end
  end

  assign chain_tok[0] = tok_launch;
  assign chain_idx[0] = '0;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    lprt_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (i)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .tok_in       (chain_tok[i]),
      .free_idx_in  (chain_idx[i]),
      .wr           (wr),
      .wr_idx       (chain_idx[TABLE_ENTRIES]),
      .tok_out      (chain_tok[i+1]),
      .free_idx_out (chain_idx[i+1])
    );
    assign chain_vld[i] = chain_tok[i+1].vld;
  end

  assign last = chain_tok[TABLE_ENTRIES];

  always_comb begin
    wr.en       = last.vld && (last.func == lprt_pkg::FUNC_INSERT) && !last.hit
                  && last.free_found;
    wr.prefix   = last.addr;
    wr.len      = last.len;
    wr.next_hop = last.next_hop;
    wr.port     = last.port;
    wr.metric   = last.metric;

    rsp_next.status         = lprt_pkg::STATUS_NOT_FOUND;
    rsp_next.found_next_hop = '0;
    rsp_next.found_port     = '0;
    rsp_next.found_metric   = '0;
    case (last.func)
      lprt_pkg::FUNC_INSERT: begin
        if (last.hit) begin
          rsp_next.status = lprt_pkg::STATUS_REPLACED;
        end else if (last.free_found) begin
          rsp_next.status = lprt_pkg::STATUS_DONE;
        end else begin
          rsp_next.status = lprt_pkg::STATUS_FULL;
        end
      end
      lprt_pkg::FUNC_DELETE: begin
        if (last.hit) begin
          rsp_next.status = lprt_pkg::STATUS_DONE;
        end
      end
      lprt_pkg::FUNC_QUERY: begin
        if (last.hit) begin
          rsp_next.status         = lprt_pkg::STATUS_DONE;
          rsp_next.found_next_hop = last.next_hop;
          rsp_next.found_port     = last.port;
          rsp_next.found_metric   = last.metric;
        end
      end
      default: begin
        rsp_next.status = lprt_pkg::STATUS_NOT_FOUND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (last.vld) begin
      rsp <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      busy <= 1'b0;
    end else begin
      done <= last.vld;
      if (accept) begin
        busy <= 1'b1;
      end else if (last.vld) begin
        busy <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_one_command: assert property (@(posedge clk) disable iff (rst)
    $countones({chain_vld, tok_launch.vld}) <= 1)
    else $error("More than one command is travelling along the row.");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("Busy did not rise after an accepted transfer.");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && !tok_launch.vld && (chain_vld == '0)))
    else $error("A result appeared without a command having finished its walk.");

  a_write_on_insert: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (last.vld && (last.func == lprt_pkg::FUNC_INSERT)))
    else $error("A table write was issued outside the end of an insert.");
`endif

endmodule

// File: rtl/lprt_cell.sv
// One route slot of the table, which checks and updates the command passing through it.
module lprt_cell #(
  parameter int IDX_W    = 6,
  parameter int CELL_IDX = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  lprt_pkg::tok_t      tok_in,
  input  logic [IDX_W-1:0]    free_idx_in,
  input  lprt_pkg::wr_t       wr,
  input  logic [IDX_W-1:0]    wr_idx,
  output lprt_pkg::tok_t      tok_out,
  output logic [IDX_W-1:0]    free_idx_out
);

  logic                          valid;
  logic [lprt_pkg::ADDR_W-1:0]   prefix;
  logic [lprt_pkg::LEN_W-1:0]    len;
  logic [lprt_pkg::ADDR_W-1:0]   next_hop;
  logic [lprt_pkg::PORT_W-1:0]   port;
  logic [lprt_pkg::MET_W-1:0]    metric;

  lprt_pkg::tok_t   tok_next;
  logic [IDX_W-1:0] free_idx_next;
  logic             match_exact;
  logic             match_query;
  logic             upd;
  logic             clr;
  logic             wr_hit;

  assign wr_hit = wr.en && (wr_idx == IDX_W'(CELL_IDX));

  always_comb begin
    match_exact   = valid && (len == tok_in.len) && (prefix == tok_in.addr);
    match_query   = valid && (prefix == (tok_in.addr & lprt_pkg::len_mask(len)))
                    && (!tok_in.hit || (len > tok_in.len));
    tok_next      = tok_in;
    free_idx_next = free_idx_in;
    upd           = 1'b0;
    clr           = 1'b0;
    if (tok_in.vld) begin
      case (tok_in.func)
        lprt_pkg::FUNC_INSERT: begin
          if (match_exact) begin
            tok_next.hit = 1'b1;
            upd          = 1'b1;
          end
          if (!valid && !tok_in.free_found) begin
            tok_next.free_found = 1'b1;
            free_idx_next       = IDX_W'(CELL_IDX);
          end
        end
        lprt_pkg::FUNC_DELETE: begin
          if (match_exact) begin
            tok_next.hit = 1'b1;
            clr          = 1'b1;
          end
        end
        lprt_pkg::FUNC_QUERY: begin
          if (match_query) begin
            tok_next.hit      = 1'b1;
            tok_next.len      = len;
            tok_next.next_hop = next_hop;
            tok_next.port     = port;
            tok_next.metric   = metric;
          end
        end
        default: begin
          tok_next = tok_in;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (upd || wr_hit) begin
      valid <= 1'b1;
    end else if (clr) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      prefix   <= tok_in.addr;
      len      <= tok_in.len;
      next_hop <= tok_in.next_hop;
      port     <= tok_in.port;
      metric   <= tok_in.metric;
    end else if (wr_hit) begin
      prefix   <= wr.prefix;
      len      <= wr.len;
      next_hop <= wr.next_hop;
      port     <= wr.port;
      metric   <= wr.metric;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
    free_idx_out <= free_idx_next;
  end

endmodule
